/* design/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg
// Shared widths, codes and reset values for the binary trie lookup block.
// ----------------------------------------------------------------------------
package bti_pkg;

  // Field widths.
  localparam int PTR_W     = 24;  // trie pointer and country index
  localparam int IDX_W     = 16;  // node index carried by a load beat
  localparam int ADDR_BITS = 32;  // IPv4 address bits walked per lookup
  localparam int LVL_W     = $clog2(ADDR_BITS);
  localparam int NODE_W    = 2 * PTR_W;  // right pointer above left pointer
  localparam int STATUS_W  = 2;

  // Default trie size.
  localparam int NODE_COUNT = 65536;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, indexed by paddr[2].
  localparam logic REG_LEAF_BASE = 1'b0;

  localparam logic [PTR_W-1:0] LEAF_BASE_RESET = 24'd16776960;

  // Commands carried by an input beat.
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Lookup outcome.
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND        = 2'd0,
    ST_NO_LEAF      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_e;

endpackage

/* design/bti_if.sv */
// ----------------------------------------------------------------------------
// bti_req_if / bti_rsp_if
// Valid/ready channels for load and lookup beats and for lookup results.
// ----------------------------------------------------------------------------
interface bti_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bti_pkg::IDX_W-1:0]   node_index;
  logic [bti_pkg::PTR_W-1:0]   left_pointer;
  logic [bti_pkg::PTR_W-1:0]   right_pointer;
  logic [bti_pkg::ADDR_BITS-1:0] ip_address;

  modport source (
    output valid, command, node_index, left_pointer, right_pointer, ip_address,
    input  ready
  );
  modport sink (
    input  valid, command, node_index, left_pointer, right_pointer, ip_address,
    output ready
  );
endinterface

interface bti_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bti_pkg::PTR_W-1:0]      country_index;
  logic [bti_pkg::STATUS_W-1:0]   status;

  modport source (output valid, country_index, status, input ready);
  modport sink (input valid, country_index, status, output ready);
endinterface

/* design/binary_trie_ip_lookup.sv */
// ----------------------------------------------------------------------------
// binary_trie_ip_lookup
// Longest-prefix lookup of IPv4 addresses in a binary trie held in node RAM.
// ----------------------------------------------------------------------------
// A load beat writes one trie node; it is taken only when no lookup is
// walking the trie. A lookup beat walks its 32 address bits through a
// three-stage loop around the node RAM (issue read, RAM data, pointer select
// and compare), one trie level per pass, and its result is then held in the
// result register. The loop holds up to three lookups at once, so a new
// lookup can enter while others are still walking; every lookup makes all 32
// passes, so results leave in the order the lookups came in. The leaf_base
// register is at byte address 0; the user must write it only while the block
// is idle, as the block itself does not enforce this. The node RAM has no
// reset; nodes must be loaded before a lookup reaches them.
module binary_trie_ip_lookup #(
  parameter int NODE_COUNT = bti_pkg::NODE_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bti_pkg::PADDR_W-1:0] paddr,
  input  logic [bti_pkg::PDATA_W-1:0] pwdata,
  output logic [bti_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Load and lookup beats in, lookup results out.
  bti_req_if.sink                     req_i,
  bti_rsp_if.source                   rsp_o
);

  localparam int PTR_W  = bti_pkg::PTR_W;
  localparam int AW     = $clog2(NODE_COUNT);
  localparam int LVL_W  = bti_pkg::LVL_W;
  localparam int ABITS  = bti_pkg::ADDR_BITS;
  localparam logic [PTR_W:0] NODE_LIMIT = (PTR_W + 1)'(NODE_COUNT);
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(ABITS - 1);

  // One lookup as it travels around the loop.
  typedef struct packed {
    logic                  done;
    bti_pkg::status_e      status;
    logic [PTR_W-1:0]      country;
    logic [ABITS-1:0]      ip;
    logic [LVL_W-1:0]      lvl;
    logic [AW-1:0]         node;
  } slot_t;

  logic [PTR_W-1:0] leaf_base_q;

  logic  s0_v_q, s1_v_q, s2_v_q;
  slot_t s0_q, s1_q, s2_q;
  slot_t s2_d, entry;

  logic out_v_q;
  logic [PTR_W-1:0] out_country_q;
  bti_pkg::status_e out_status_q;

  logic [bti_pkg::NODE_W-1:0] rdata;
  logic [PTR_W-1:0] ptr;

  logic exit_now, adv, slot_free, ring_empty;
  logic load_acc, lookup_acc, load_in_range, cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == bti_pkg::REG_LEAF_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_base_q <= bti_pkg::LEAF_BASE_RESET;
    end else if (cfg_wr) begin
      leaf_base_q <= pwdata[PTR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bti_pkg::REG_LEAF_BASE) ?
                  bti_pkg::PDATA_W'(leaf_base_q) : '0;

  // Loop control: the loop freezes only when a finished lookup cannot leave.
  assign exit_now   = s2_v_q && (s2_q.lvl == '0);
  assign adv        = !(exit_now && out_v_q && !rsp_o.ready);
  assign slot_free  = !s2_v_q || exit_now;
  assign ring_empty = !s0_v_q && !s1_v_q && !s2_v_q;

  // Beat acceptance: loads wait for an empty loop, lookups for a free slot.
  always_comb begin
    if (bti_pkg::cmd_e'(req_i.command) == bti_pkg::CMD_LOOKUP) begin
      req_i.ready = adv && slot_free;
    end else begin
      req_i.ready = ring_empty;
    end
  end

  assign lookup_acc = req_i.valid && req_i.ready &&
                      (bti_pkg::cmd_e'(req_i.command) == bti_pkg::CMD_LOOKUP);
  assign load_acc   = req_i.valid && req_i.ready &&
                      (bti_pkg::cmd_e'(req_i.command) == bti_pkg::CMD_LOAD);
  assign load_in_range = {{(PTR_W + 1 - bti_pkg::IDX_W){1'b0}}, req_i.node_index} < NODE_LIMIT;

  // Node RAM: written by loads, read at the node held in the issue stage.
  bti_ram #(
    .WIDTH (bti_pkg::NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc && load_in_range),
    .waddr_i (AW'(req_i.node_index)),
    .wdata_i ({req_i.right_pointer, req_i.left_pointer}),
    .re_i    (adv),
    .raddr_i (s0_q.node),
    .rdata_o (rdata)
  );

  // A new lookup starts at node 0 at the first level.
  always_comb begin
    entry         = '0;
    entry.status  = bti_pkg::ST_NO_LEAF;
    entry.ip      = req_i.ip_address;
  end

  // Level step: pick the pointer for the current address bit and classify it.
  assign ptr = s1_q.ip[ABITS-1] ? rdata[2*PTR_W-1:PTR_W] : rdata[PTR_W-1:0];

  always_comb begin
    s2_d     = s1_q;
    s2_d.ip  = {s1_q.ip[ABITS-2:0], 1'b0};
    s2_d.lvl = s1_q.lvl + LVL_W'(1);
    if (!s1_q.done) begin
      if (ptr >= leaf_base_q) begin
        s2_d.done    = 1'b1;
        s2_d.status  = bti_pkg::ST_FOUND;
        s2_d.country = ptr - leaf_base_q;
      end else if (s1_q.lvl == LAST_LVL) begin
        s2_d.done    = 1'b1;
        s2_d.status  = bti_pkg::ST_NO_LEAF;
      end else if ({1'b0, ptr} >= NODE_LIMIT) begin
        s2_d.done    = 1'b1;
        s2_d.status  = bti_pkg::ST_OUT_OF_RANGE;
      end else begin
        s2_d.node    = AW'(ptr);
      end
    end
  end

  // Loop valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= slot_free ? lookup_acc : 1'b1;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  // Loop payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= slot_free ? entry : s2_q;
      s1_q <= s0_q;
      s2_q <= s2_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && exit_now) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && exit_now) begin
      out_country_q <= s2_q.country;
      out_status_q  <= s2_q.status;
    end
  end

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.country_index = out_country_q;
  assign rsp_o.status        = out_status_q;

endmodule

/* design/bti_ram.sv */
// ----------------------------------------------------------------------------
// bti_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bti_ram #(
  parameter int WIDTH = bti_pkg::NODE_W,
  parameter int DEPTH = bti_pkg::NODE_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
